>>> hdl/tqbw_pkg.sv
// Shared package for the transfer queue byte window unit.
// Holds entry state codes, operation codes and the controller/datapath link types.
// No dependencies.
`timescale 1ns / 1ps

package tqbw_pkg;

  // Per-entry state codes.
  localparam int STATE_W = 2;
  localparam logic [STATE_W-1:0] ST_NONE     = 2'd0;
  localparam logic [STATE_W-1:0] ST_PENDING  = 2'd1;
  localparam logic [STATE_W-1:0] ST_INFLIGHT = 2'd2;

  // Operation codes carried on func.
  localparam int FUNC_W = 3;
  localparam logic [FUNC_W-1:0] FN_ENQUEUE  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_CLAIM    = 3'd1;
  localparam logic [FUNC_W-1:0] FN_RETURN   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_PUBLISH  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_COMPLETE = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture the accepted transfer
    logic exec;   // evaluate the operation and update lists
    logic link;   // write the old tail's link
    logic clear;  // clear one entry state after reset
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_link;   // the append found a non-empty list
    logic clear_done;  // the last entry is being cleared
  } dp_stat_t;

endpackage

>>> hdl/tqbw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module tqbw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/tqbw_ctrl.sv
// Controller for the transfer queue byte window unit.
// Sequences clear, execute and link steps; depends on tqbw_pkg.
`timescale 1ns / 1ps

module tqbw_ctrl
  import tqbw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_stat_t   stat,
  output ctrl_cmd_t  cmd,
  output logic       busy,
  output logic       done
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;
  localparam logic [1:0] S_LINK  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       done_next;

  // Next state and completion of the current transfer.
  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    unique case (state)
      S_CLEAR: begin
        if (stat.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.need_link) begin
          state_next = S_LINK;
        end else begin
          state_next = S_IDLE;
          done_next  = 1'b1;
        end
      end
      S_LINK: begin
        state_next = S_IDLE;
        done_next  = 1'b1;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and strobe registers; reset starts the entry clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  // Commands to the datapath.
  assign cmd.load  = (state == S_IDLE) && start;
  assign cmd.exec  = (state == S_EXEC);
  assign cmd.link  = (state == S_LINK);
  assign cmd.clear = (state == S_CLEAR);
  assign busy      = (state != S_IDLE);

endmodule

>>> hdl/tqbw_datapath.sv
// Datapath for the transfer queue byte window unit: list heads and tails,
// link and entry state memories, in-flight counters and the byte window.
// Depends on tqbw_pkg and tqbw_ram.
`timescale 1ns / 1ps

module tqbw_datapath
  import tqbw_pkg::*;
#(
  parameter int MAX_ACTIONS = 64,
  parameter int BYTE_WIDTH  = 48,
  localparam int IW = $clog2(MAX_ACTIONS),
  localparam int LW = $clog2(MAX_ACTIONS + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_cmd_t             cmd,
  output dp_stat_t              stat,
  input  logic                  window_bytes_we,
  input  logic [BYTE_WIDTH-1:0] window_bytes,
  input  logic [FUNC_W-1:0]     func,
  input  logic [IW-1:0]         action_id,
  input  logic                  is_background,
  input  logic [BYTE_WIDTH-1:0] object_bytes,
  output logic                  status,
  output logic [IW-1:0]         inflight_head_id,
  output logic                  inflight_head_valid,
  output logic [LW-1:0]         inflight_total,
  output logic [BYTE_WIDTH-1:0] background_bytes_out,
  output logic                  foreground_empty,
  output logic                  background_empty
);

  localparam logic [LW-1:0] NULL_LINK = LW'(MAX_ACTIONS);
  localparam logic [LW-1:0] MAX_COUNT = LW'(MAX_ACTIONS);
  localparam logic [IW-1:0] LAST_ID   = IW'(MAX_ACTIONS - 1);

  // Captured transfer.
  logic [FUNC_W-1:0]     func_q;
  logic [IW-1:0]         id_q;
  logic                  bg_q;
  logic [BYTE_WIDTH-1:0] size_q;

  // List and counter state.
  logic [LW-1:0]         head_fg, head_bg, head_fly;
  logic [LW-1:0]         tail_fg, tail_bg, tail_fly;
  logic [LW-1:0]         flight_count;
  logic [BYTE_WIDTH-1:0] flight_bytes;
  logic [BYTE_WIDTH-1:0] window_q;
  logic [IW-1:0]         clr_cnt;
  logic [IW-1:0]         link_addr;
  logic                  status_q;

  // Memory ports.
  logic [STATE_W-1:0]    st_rd;
  logic [LW-1:0]         nx_rd;
  logic                  st_wr_en, nx_wr_en;
  logic [IW-1:0]         st_waddr, nx_waddr;
  logic [STATE_W-1:0]    st_wdata;
  logic [LW-1:0]         nx_wdata;

  // Operation evaluation.
  logic                  use_fly;
  logic [LW-1:0]         op_head, op_tail, id_ext;
  logic                  head_null, tail_null, next_null;
  logic                  id_ok, is_head, admit, ok;
  logic [BYTE_WIDTH:0]   byte_sum;
  logic                  list_we;
  logic [LW-1:0]         head_new, tail_new;
  logic                  st_we, nx_we, link_req;
  logic [STATE_W-1:0]    st_wd;
  logic [LW-1:0]         nx_wd;
  logic                  cnt_inc, cnt_dec, bytes_add, bytes_sub;

  // Entry state and link memories, both read at the incoming identifier.
  tqbw_ram #(.WIDTH(STATE_W), .DEPTH(MAX_ACTIONS)) u_state_ram (
    .clk   (clk),
    .we    (st_wr_en),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (action_id),
    .rdata (st_rd)
  );

  tqbw_ram #(.WIDTH(LW), .DEPTH(MAX_ACTIONS)) u_link_ram (
    .clk   (clk),
    .we    (nx_wr_en),
    .waddr (nx_waddr),
    .wdata (nx_wdata),
    .raddr (action_id),
    .rdata (nx_rd)
  );

  // Evaluate the captured operation against the selected list.
  always_comb begin
    use_fly   = (func_q == FN_PUBLISH) || (func_q == FN_COMPLETE);
    op_head   = use_fly ? head_fly : (bg_q ? head_bg : head_fg);
    op_tail   = use_fly ? tail_fly : (bg_q ? tail_bg : tail_fg);
    id_ext    = LW'(id_q);
    head_null = (op_head >= NULL_LINK);
    tail_null = (op_tail >= NULL_LINK);
    next_null = (nx_rd >= NULL_LINK);
    id_ok     = (id_ext < NULL_LINK);
    is_head   = (op_head == id_ext);
    byte_sum  = {1'b0, flight_bytes} + {1'b0, size_q};
    admit     = (window_q == '0) || (flight_bytes == '0) ||
                (byte_sum <= {1'b0, window_q});

    ok        = 1'b0;
    list_we   = 1'b0;
    head_new  = op_head;
    tail_new  = op_tail;
    st_we     = 1'b0;
    st_wd     = ST_NONE;
    nx_we     = 1'b0;
    nx_wd     = NULL_LINK;
    link_req  = 1'b0;
    cnt_inc   = 1'b0;
    cnt_dec   = 1'b0;
    bytes_add = 1'b0;
    bytes_sub = 1'b0;

    if (id_ok) begin
      unique case (func_q)
        FN_ENQUEUE, FN_PUBLISH: begin
          ok       = 1'b1;
          list_we  = 1'b1;
          head_new = tail_null ? id_ext : op_head;
          tail_new = id_ext;
          st_we    = 1'b1;
          st_wd    = use_fly ? ST_INFLIGHT : ST_PENDING;
          nx_we    = 1'b1;
          link_req = !tail_null;
          cnt_inc  = use_fly;
          bytes_add = use_fly && bg_q;
        end
        FN_CLAIM, FN_COMPLETE: begin
          ok = is_head &&
               (use_fly ? (st_rd == ST_INFLIGHT)
                        : ((st_rd == ST_PENDING) && (!bg_q || admit)));
          if (ok) begin
            list_we   = 1'b1;
            head_new  = nx_rd;
            tail_new  = next_null ? NULL_LINK : op_tail;
            st_we     = 1'b1;
            nx_we     = 1'b1;
            cnt_dec   = use_fly;
            bytes_sub = use_fly && bg_q;
          end
        end
        FN_RETURN: begin
          ok       = 1'b1;
          list_we  = 1'b1;
          head_new = id_ext;
          tail_new = head_null ? id_ext : op_tail;
          st_we    = 1'b1;
          st_wd    = ST_PENDING;
          nx_we    = 1'b1;
          nx_wd    = op_head;
        end
        default: begin
        end
      endcase
    end
  end

  assign stat.need_link  = cmd.exec && link_req;
  assign stat.clear_done = cmd.clear && (clr_cnt == LAST_ID);

  // Memory write selection: clearing pass, execute step, then tail link.
  assign st_wr_en = cmd.clear || (cmd.exec && st_we);
  assign st_waddr = cmd.clear ? clr_cnt : id_q;
  assign st_wdata = cmd.clear ? ST_NONE : st_wd;
  assign nx_wr_en = cmd.link || (cmd.exec && nx_we);
  assign nx_waddr = cmd.link ? link_addr : id_q;
  assign nx_wdata = cmd.link ? id_ext : nx_wd;

  // Transfer capture and per-operation payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q <= func;
      id_q   <= action_id;
      bg_q   <= is_background;
      size_q <= object_bytes;
    end
    if (cmd.exec) begin
      status_q  <= !ok;
      link_addr <= op_tail[IW-1:0];
    end
  end

  // Control state: list pointers, counters, window and clear counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      head_fg      <= NULL_LINK;
      head_bg      <= NULL_LINK;
      head_fly     <= NULL_LINK;
      tail_fg      <= NULL_LINK;
      tail_bg      <= NULL_LINK;
      tail_fly     <= NULL_LINK;
      flight_count <= '0;
      flight_bytes <= '0;
      window_q     <= '0;
      clr_cnt      <= '0;
    end else begin
      if (window_bytes_we) begin
        window_q <= window_bytes;
      end
      if (cmd.clear) begin
        clr_cnt <= clr_cnt + IW'(1);
      end
      if (cmd.exec && list_we) begin
        if (use_fly) begin
          head_fly <= head_new;
          tail_fly <= tail_new;
        end else if (bg_q) begin
          head_bg <= head_new;
          tail_bg <= tail_new;
        end else begin
          head_fg <= head_new;
          tail_fg <= tail_new;
        end
      end
      // In-flight count saturates at the table size and floors at zero.
      if (cmd.exec && cnt_inc && (flight_count < MAX_COUNT)) begin
        flight_count <= flight_count + LW'(1);
      end else if (cmd.exec && cnt_dec && (flight_count != '0)) begin
        flight_count <= flight_count - LW'(1);
      end
      // Background bytes saturate at all ones and at zero.
      if (cmd.exec && bytes_add) begin
        flight_bytes <= byte_sum[BYTE_WIDTH] ? '1 : byte_sum[BYTE_WIDTH-1:0];
      end else if (cmd.exec && bytes_sub) begin
        flight_bytes <= (size_q > flight_bytes) ? '0 : (flight_bytes - size_q);
      end
    end
  end

  // Result fields.
  assign status               = status_q;
  assign inflight_head_valid  = (head_fly < NULL_LINK);
  assign inflight_head_id     = inflight_head_valid ? head_fly[IW-1:0] : '0;
  assign inflight_total       = flight_count;
  assign background_bytes_out = flight_bytes;
  assign foreground_empty     = (head_fg >= NULL_LINK);
  assign background_empty     = (head_bg >= NULL_LINK);

endmodule

>>> hdl/transfer_queue_byte_window_unit.sv
// Top level of the transfer queue byte window unit.
// Joins tqbw_ctrl and tqbw_datapath; depends on tqbw_pkg.
//
// Usage:
//   A transfer is accepted at a rising edge where start is high and busy is
//   low; func, action_id, is_background and object_bytes are sampled there.
//   Exactly one result follows per transfer: done is high for one cycle and
//   status plus the in-flight and pending list summary are valid in that
//   cycle. The receiver cannot stall; the result must be taken when shown.
//   After accept the unit runs an execute step, plus a link step when an
//   enqueue or publish appends behind an existing tail (the old tail's link
//   needs a second write to the link memory, which has one write port).
//   busy drops in the same cycle done rises, so a new transfer may start.
//   window_bytes is written whenever window_bytes_we is high; change it only
//   while no transfer is in progress.
//   After reset the unit clears its entry state memory one entry per cycle,
//   all MAX_ACTIONS entries, with busy held high; configuration writes are still
//   taken during that pass.
`timescale 1ns / 1ps

module transfer_queue_byte_window_unit
  import tqbw_pkg::*;
#(
  parameter int MAX_ACTIONS = 64,
  parameter int BYTE_WIDTH  = 48,
  localparam int IW = $clog2(MAX_ACTIONS),
  localparam int LW = $clog2(MAX_ACTIONS + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  output logic                  done,
  input  logic                  window_bytes_we,
  input  logic [BYTE_WIDTH-1:0] window_bytes,
  input  logic [FUNC_W-1:0]     func,
  input  logic [IW-1:0]         action_id,
  input  logic                  is_background,
  input  logic [BYTE_WIDTH-1:0] object_bytes,
  output logic                  status,
  output logic [IW-1:0]         inflight_head_id,
  output logic                  inflight_head_valid,
  output logic [LW-1:0]         inflight_total,
  output logic [BYTE_WIDTH-1:0] background_bytes_out,
  output logic                  foreground_empty,
  output logic                  background_empty
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Sequencer.
  tqbw_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Lists, memories and counters.
  tqbw_datapath #(
    .MAX_ACTIONS (MAX_ACTIONS),
    .BYTE_WIDTH  (BYTE_WIDTH)
  ) u_datapath (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .stat                 (stat),
    .window_bytes_we      (window_bytes_we),
    .window_bytes         (window_bytes),
    .func                 (func),
    .action_id            (action_id),
    .is_background        (is_background),
    .object_bytes         (object_bytes),
    .status               (status),
    .inflight_head_id     (inflight_head_id),
    .inflight_head_valid  (inflight_head_valid),
    .inflight_total       (inflight_total),
    .background_bytes_out (background_bytes_out),
    .foreground_empty     (foreground_empty),
    .background_empty     (background_empty)
  );

endmodule

>>> verif/tb_transfer_queue_byte_window_unit.sv
// Self-checking testbench for transfer_queue_byte_window_unit.
// Drives directed and random transfers, predicts each result in place and checks it.
// Depends on tqbw_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb_transfer_queue_byte_window_unit;
  import tqbw_pkg::*;

  localparam int MAX_IDS = 64;
  localparam int BYTES_W = 48;
  localparam int NUM_DIR = 25;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [6:0] NULL_ID = 7'd64;
  localparam logic [6:0] COUNT_CAP = 7'd64;
  localparam logic [BYTES_W-1:0] BYTE_MAX = {BYTES_W{1'b1}};

  // List indexes inside the shared link store.
  localparam logic [1:0] LIST_FG = 2'd0;
  localparam logic [1:0] LIST_BG = 2'd1;
  localparam logic [1:0] LIST_FLY = 2'd2;

  // Result status codes and the operation codes the unit does not define.
  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;
  localparam logic [FUNC_W-1:0] FN_UNUSED_LO = 3'd5;
  localparam logic [FUNC_W-1:0] FN_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic               status;
    logic [5:0]         head_id;
    logic               head_valid;
    logic [6:0]         total;
    logic [BYTES_W-1:0] bytes;
    logic               fg_empty;
    logic               bg_empty;
  } summary_t;

  typedef struct packed {
    logic [FUNC_W-1:0]  fn;
    logic [5:0]         id;
    logic               bg;
    logic [BYTES_W-1:0] size;
    logic               typed;
    summary_t           want;
  } dir_row_t;

  typedef struct packed {
    logic [5:0]         id;
    logic               bg;
    logic [BYTES_W-1:0] size;
  } claim_rec_t;

  localparam summary_t IDLE_REFUSED = '{STATUS_REFUSED, 6'd0, 1'b0, 7'd0, 48'd0, 1'b1, 1'b1};

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic                done;
  logic                window_bytes_we;
  logic [BYTES_W-1:0]  window_bytes;
  logic [FUNC_W-1:0]   func;
  logic [5:0]          action_id;
  logic                is_background;
  logic [BYTES_W-1:0]  object_bytes;
  logic                status;
  logic [5:0]          inflight_head_id;
  logic                inflight_head_valid;
  logic [6:0]          inflight_total;
  logic [BYTES_W-1:0]  background_bytes_out;
  logic                foreground_empty;
  logic                background_empty;

  // Shadow of the queue state, updated as each transfer is accepted.
  logic [6:0]          link_mem [MAX_IDS];
  logic [STATE_W-1:0]  ent_state [MAX_IDS];
  logic [6:0]          head_of [3];
  logic [6:0]          tail_of [3];
  logic [6:0]          fly_count;
  logic [BYTES_W-1:0]  fly_bytes;
  logic [BYTES_W-1:0]  window_reg;

  // Stimulus bookkeeping for well-formed sequences.
  logic [BYTES_W-1:0]  enq_size [MAX_IDS];
  logic [BYTES_W-1:0]  pub_size [MAX_IDS];
  logic                pub_bg [MAX_IDS];
  claim_rec_t          claimed [$];

  summary_t            due_summaries [$];
  int                  err_count = 0;
  int                  checked_count = 0;
  int                  transfer_count;
  int                  refused_count;
  int                  window_settings;
  int                  cycle_count = 0;

  dir_row_t dir_rows [NUM_DIR] = '{
    '{FN_COMPLETE,  6'd0,  1'b0, 48'd0,    1'b1, IDLE_REFUSED},
    '{FN_CLAIM,     6'd5,  1'b0, 48'd0,    1'b1, IDLE_REFUSED},
    '{FN_UNUSED_LO, 6'd63, 1'b1, BYTE_MAX, 1'b1, IDLE_REFUSED},
    '{FN_ENQUEUE,   6'd0,  1'b0, 48'd0,    1'b0, '0},
    '{FN_ENQUEUE,   6'd63, 1'b1, BYTE_MAX, 1'b0, '0},
    '{FN_RETURN,    6'd10, 1'b0, 48'd0,    1'b0, '0},
    '{FN_CLAIM,     6'd0,  1'b0, 48'd0,    1'b0, '0},
    '{FN_CLAIM,     6'd10, 1'b0, 48'd0,    1'b0, '0},
    '{FN_CLAIM,     6'd0,  1'b0, 48'd0,    1'b0, '0},
    '{FN_CLAIM,     6'd63, 1'b1, BYTE_MAX, 1'b0, '0},
    '{FN_PUBLISH,   6'd63, 1'b1, BYTE_MAX, 1'b1,
      '{STATUS_DONE, 6'd63, 1'b1, 7'd1, BYTE_MAX, 1'b1, 1'b1}},
    '{FN_PUBLISH,   6'd0,  1'b1, BYTE_MAX, 1'b1,
      '{STATUS_DONE, 6'd63, 1'b1, 7'd2, BYTE_MAX, 1'b1, 1'b1}},
    '{FN_COMPLETE,  6'd0,  1'b1, 48'd0,    1'b1,
      '{STATUS_REFUSED, 6'd63, 1'b1, 7'd2, BYTE_MAX, 1'b1, 1'b1}},
    '{FN_COMPLETE,  6'd63, 1'b1, 48'd1,    1'b1,
      '{STATUS_DONE, 6'd0, 1'b1, 7'd1, BYTE_MAX - 48'd1, 1'b1, 1'b1}},
    '{FN_COMPLETE,  6'd0,  1'b1, BYTE_MAX, 1'b1,
      '{STATUS_DONE, 6'd0, 1'b0, 7'd0, 48'd0, 1'b1, 1'b1}},
    '{FN_PUBLISH,   6'd20, 1'b1, 48'd100,  1'b0, '0},
    '{FN_ENQUEUE,   6'd1,  1'b1, 48'd60,   1'b0, '0},
    '{FN_CLAIM,     6'd1,  1'b1, 48'd60,   1'b0, '0},
    '{FN_CLAIM,     6'd1,  1'b1, 48'd50,   1'b0, '0},
    '{FN_ENQUEUE,   6'd2,  1'b1, 48'd0,    1'b0, '0},
    '{FN_PUBLISH,   6'd21, 1'b1, 48'd200,  1'b0, '0},
    '{FN_CLAIM,     6'd2,  1'b1, 48'd0,    1'b0, '0},
    '{FN_ENQUEUE,   6'd3,  1'b0, 48'd0,    1'b0, '0},
    '{FN_CLAIM,     6'd3,  1'b0, BYTE_MAX, 1'b0, '0},
    '{FN_COMPLETE,  6'd20, 1'b1, 48'd100,  1'b0, '0}
  };

  transfer_queue_byte_window_unit #(
    .MAX_ACTIONS(MAX_IDS),
    .BYTE_WIDTH (BYTES_W)
  ) i_dut (
    .clk                 (clk),
    .rst                 (rst),
    .start               (start),
    .busy                (busy),
    .done                (done),
    .window_bytes_we     (window_bytes_we),
    .window_bytes        (window_bytes),
    .func                (func),
    .action_id           (action_id),
    .is_background       (is_background),
    .object_bytes        (object_bytes),
    .status              (status),
    .inflight_head_id    (inflight_head_id),
    .inflight_head_valid (inflight_head_valid),
    .inflight_total      (inflight_total),
    .background_bytes_out(background_bytes_out),
    .foreground_empty    (foreground_empty),
    .background_empty    (background_empty)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [BYTES_W-1:0] rand_bytes();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[BYTES_W-1:0];
  endfunction

  // Mostly small sizes, with zero, the maximum and full-width values mixed in.
  function automatic logic [BYTES_W-1:0] pick_size();
    int u;
    u = $urandom_range(0, 99);
    if (u < 8) return rand_bytes();
    if (u < 12) return '0;
    if (u < 14) return BYTE_MAX;
    return BYTES_W'($urandom_range(1, 200));
  endfunction

  // Append an identifier at the tail of one list.
  function automatic void append_id(logic [1:0] lst, logic [6:0] id7);
    logic [6:0] t;
    t = tail_of[lst];
    link_mem[id7[5:0]] = NULL_ID;
    if (t == NULL_ID) head_of[lst] = id7;
    else link_mem[t[5:0]] = id7;
    tail_of[lst] = id7;
  endfunction

  // Remove the head of one list and mark it free.
  function automatic void pop_id(logic [1:0] lst, logic [6:0] id7);
    logic [6:0] n;
    n = link_mem[id7[5:0]];
    head_of[lst] = n;
    if (n == NULL_ID) tail_of[lst] = NULL_ID;
    link_mem[id7[5:0]] = NULL_ID;
    ent_state[id7[5:0]] = ST_NONE;
  endfunction

  // Apply one transfer to the shadow state and return the summary it produces.
  function automatic summary_t apply_transfer(logic [FUNC_W-1:0] fn, logic [5:0] id, logic bg,
                                              logic [BYTES_W-1:0] size);
    summary_t   s;
    logic [1:0] pl;
    logic [6:0] id7;
    logic       ok;
    logic       fits;
    pl = bg ? LIST_BG : LIST_FG;
    id7 = {1'b0, id};
    ok = 1'b0;
    case (fn)
      FN_ENQUEUE: begin
        ent_state[id] = ST_PENDING;
        append_id(pl, id7);
        ok = 1'b1;
      end
      FN_CLAIM: begin
        // Background claims must fit the window unless it is open or nothing is out.
        if (window_reg == '0 || fly_bytes == '0) fits = 1'b1;
        else if (fly_bytes > window_reg) fits = 1'b0;
        else fits = (size <= window_reg - fly_bytes);
        if (head_of[pl] == id7 && ent_state[id] == ST_PENDING && (!bg || fits)) begin
          pop_id(pl, id7);
          ok = 1'b1;
        end
      end
      FN_RETURN: begin
        link_mem[id] = head_of[pl];
        if (head_of[pl] == NULL_ID) tail_of[pl] = id7;
        head_of[pl] = id7;
        ent_state[id] = ST_PENDING;
        ok = 1'b1;
      end
      FN_PUBLISH: begin
        ent_state[id] = ST_INFLIGHT;
        append_id(LIST_FLY, id7);
        if (fly_count < COUNT_CAP) fly_count = fly_count + 7'd1;
        if (bg) fly_bytes = (size > BYTE_MAX - fly_bytes) ? BYTE_MAX : fly_bytes + size;
        ok = 1'b1;
      end
      FN_COMPLETE: begin
        if (head_of[LIST_FLY] == id7 && ent_state[id] == ST_INFLIGHT) begin
          pop_id(LIST_FLY, id7);
          if (fly_count != 7'd0) fly_count = fly_count - 7'd1;
          if (bg) fly_bytes = (size > fly_bytes) ? '0 : fly_bytes - size;
          ok = 1'b1;
        end
      end
      default: ;
    endcase
    s.status = ok ? STATUS_DONE : STATUS_REFUSED;
    s.head_valid = (head_of[LIST_FLY] != NULL_ID);
    s.head_id = s.head_valid ? head_of[LIST_FLY][5:0] : 6'd0;
    s.total = fly_count;
    s.bytes = fly_bytes;
    s.fg_empty = (head_of[LIST_FG] == NULL_ID);
    s.bg_empty = (head_of[LIST_BG] == NULL_ID);
    return s;
  endfunction

  task automatic report_mismatch(string msg);
    err_count++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // Present one transfer from a falling edge and hold it until it is accepted.
  task automatic send_transfer(logic [FUNC_W-1:0] fn, logic [5:0] id, logic bg,
                               logic [BYTES_W-1:0] size, logic typed, summary_t want);
    summary_t s;
    start <= 1'b1;
    func <= fn;
    action_id <= id;
    is_background <= bg;
    object_bytes <= size;
    do @(posedge clk); while (busy);
    s = apply_transfer(fn, id, bg, size);
    due_summaries.push_back(typed ? want : s);
    transfer_count++;
    if (s.status == STATUS_REFUSED) refused_count++;
    if (fn == FN_ENQUEUE) enq_size[id] = size;
    if (fn == FN_CLAIM && s.status == STATUS_DONE) claimed.push_back('{id, bg, size});
    if (fn == FN_PUBLISH) begin
      pub_bg[id] = bg;
      pub_size[id] = size;
    end
    @(negedge clk);
  endtask

  // Stop sending until every outstanding result has come back.
  task automatic drain_transfers();
    start <= 1'b0;
    while (due_summaries.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_window(logic [BYTES_W-1:0] value);
    window_bytes_we <= 1'b1;
    window_bytes <= value;
    window_reg = value;
    window_settings++;
    @(negedge clk);
    window_bytes_we <= 1'b0;
  endtask

  // Random transfers, mostly well-formed enqueue/claim/publish/complete chains.
  task automatic run_random(int count, bit idling);
    int                 k;
    int                 pick;
    int                 tries;
    bit                 idle_on;
    logic [FUNC_W-1:0]  fn;
    logic [5:0]         id;
    logic               bg;
    logic [BYTES_W-1:0] size;
    logic [1:0]         pl;
    claim_rec_t         rec;
    idle_on = 1'b0;
    for (k = 0; k < count; k++) begin
      if (k % 40 == 0) idle_on = idling && ($urandom_range(0, 1) == 1);
      if (idle_on && $urandom_range(0, 2) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
      end
      pick = $urandom_range(0, 99);
      id = 6'($urandom_range(0, MAX_IDS - 1));
      bg = 1'($urandom_range(0, 1));
      size = pick_size();
      if (pick < 4) begin
        fn = FUNC_W'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
      end else if (pick < 28) begin
        fn = FN_ENQUEUE;
        tries = 0;
        while (ent_state[id] != ST_NONE && tries < 8) begin
          id = 6'($urandom_range(0, MAX_IDS - 1));
          tries++;
        end
      end else if (pick < 50) begin
        fn = FN_CLAIM;
        pl = bg ? LIST_BG : LIST_FG;
        if (head_of[pl] != NULL_ID && $urandom_range(0, 9) != 0) begin
          id = head_of[pl][5:0];
          if ($urandom_range(0, 4) != 0) size = enq_size[id];
        end
      end else if (pick < 56) begin
        fn = FN_RETURN;
        if (claimed.size() != 0 && $urandom_range(0, 1) == 1) begin
          rec = claimed.pop_back();
          id = rec.id;
          bg = rec.bg;
        end
      end else if (pick < 78) begin
        fn = FN_PUBLISH;
        if (claimed.size() != 0 && $urandom_range(0, 6) != 0) begin
          rec = claimed.pop_front();
          id = rec.id;
          bg = rec.bg;
          size = rec.size;
        end
      end else begin
        fn = FN_COMPLETE;
        if (head_of[LIST_FLY] != NULL_ID && $urandom_range(0, 6) != 0) begin
          id = head_of[LIST_FLY][5:0];
          bg = pub_bg[id];
          size = pub_size[id];
        end
      end
      send_transfer(fn, id, bg, size, 1'b0, '0);
    end
  endtask

  // Check each result against the oldest outstanding summary.
  always @(posedge clk) begin
    summary_t want;
    if (!rst && done) begin
      if (due_summaries.size() == 0) begin
        report_mismatch("result arrived with no transfer outstanding");
      end else begin
        want = due_summaries.pop_front();
        checked_count++;
        if (status !== want.status)
          report_mismatch($sformatf("status %0b, want %0b", status, want.status));
        if (inflight_head_id !== want.head_id)
          report_mismatch($sformatf("inflight_head_id %0d, want %0d",
                                    inflight_head_id, want.head_id));
        if (inflight_head_valid !== want.head_valid)
          report_mismatch($sformatf("inflight_head_valid %0b, want %0b",
                                    inflight_head_valid, want.head_valid));
        if (inflight_total !== want.total)
          report_mismatch($sformatf("inflight_total %0d, want %0d", inflight_total, want.total));
        if (background_bytes_out !== want.bytes)
          report_mismatch($sformatf("background_bytes_out %0h, want %0h",
                                    background_bytes_out, want.bytes));
        if (foreground_empty !== want.fg_empty)
          report_mismatch($sformatf("foreground_empty %0b, want %0b",
                                    foreground_empty, want.fg_empty));
        if (background_empty !== want.bg_empty)
          report_mismatch($sformatf("background_empty %0b, want %0b",
                                    background_empty, want.bg_empty));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int                 i;
    logic [BYTES_W-1:0] windows [6];
    rst = 1'b1;
    start = 1'b0;
    window_bytes_we = 1'b0;
    window_bytes = '0;
    func = FN_ENQUEUE;
    action_id = '0;
    is_background = 1'b0;
    object_bytes = '0;
    transfer_count = 0;
    refused_count = 0;
    window_settings = 0;
    for (i = 0; i < MAX_IDS; i++) begin
      link_mem[i[5:0]] = NULL_ID;
      ent_state[i[5:0]] = ST_NONE;
      enq_size[i[5:0]] = '0;
      pub_size[i[5:0]] = '0;
      pub_bg[i[5:0]] = 1'b0;
    end
    for (i = 0; i < 3; i++) begin
      head_of[i[1:0]] = NULL_ID;
      tail_of[i[1:0]] = NULL_ID;
    end
    fly_count = '0;
    fly_bytes = '0;
    window_reg = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The window write lands during the clearing pass; transfers wait on busy.
    write_window(48'd150);
    for (i = 0; i < NUM_DIR; i++)
      send_transfer(dir_rows[i[4:0]].fn, dir_rows[i[4:0]].id, dir_rows[i[4:0]].bg,
                    dir_rows[i[4:0]].size, dir_rows[i[4:0]].typed, dir_rows[i[4:0]].want);

    // Random phases, each under a different byte window.
    windows[0] = '0;
    windows[1] = 48'd400;
    windows[2] = BYTE_MAX;
    windows[3] = rand_bytes();
    windows[4] = 48'd1;
    windows[5] = 48'd300;
    for (i = 0; i < 6; i++) begin
      drain_transfers();
      write_window(windows[i[2:0]]);
      run_random(290, i < 5);
    end

    // Fill the in-flight list past its count limit, then retire a few heads.
    for (i = 0; i < MAX_IDS + 2; i++)
      send_transfer(FN_PUBLISH, 6'(i % MAX_IDS), 1'($urandom_range(0, 1)),
                    BYTES_W'($urandom_range(0, 200)), 1'b0, '0);
    for (i = 0; i < 4; i++)
      send_transfer(FN_COMPLETE, head_of[LIST_FLY][5:0], pub_bg[head_of[LIST_FLY][5:0]],
                    pub_size[head_of[LIST_FLY][5:0]], 1'b0, '0);

    start <= 1'b0;
    while (due_summaries.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d transfers (%0d refused) under %0d byte window settings.",
             transfer_count, refused_count, window_settings);
    $display("Checked %0d results, %0d mismatches.", checked_count, err_count);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
